// ===== hw/rtl/fesg_pkg.sv =====
// Package for the filled ellipse span generator.
// Holds the sequencer state type and the request action codes; no dependencies.
`default_nettype none

package fesg_pkg;

  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_CONTINUE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_INIT,
    ST_LOAD,
    ST_CHECK,
    ST_ADD_X,
    ST_ADD_Y,
    ST_OUT_UP,
    ST_OUT_LO
  } fesg_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/filled_ellipse_span_generator.sv =====
// Top level of the filled ellipse span generator: sequencer plus one shared multiplier.
// Depends on fesg_pkg for the state type and action codes.
//
// Usage:
//   in_*  : one request per row pair. tuser = action (start or continue), tdata carries
//           center and radii, read only on start. A continue with no shape running is dropped.
//   out_* : two spans per request not dropped, upper row first, then lower row with tlast set.
//           tuser flags the final row (y = 0), after which the shape is finished.
// Sequence:
//   in_tready is high only while idle; one request is processed at a time.
//   Start: setup states SQ_A, SQ_B, INIT and LOAD (a*a, b*b, b*b*a, load), then the row step.
//   Row step: CHECK and ADD_X alternate once per x advance of that row, then a final CHECK
//   and the ADD_Y error update; each CHECK feeds the single registered multiplier, whose
//   product the ADD state accumulates. Then the output states OUT_UP and OUT_LO.
// Stalls: a span waits in out_tdata while out_tready is low; the sequencer holds.
// Reset: rst_n (synchronous, active low) returns to idle with no shape running.
`default_nettype none

module filled_ellipse_span_generator #(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 16,
  localparam int IN_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // center_x, center_y, radius_x, radius_y
  input  wire logic [IN_W-1:0]  in_tdata,
  // action
  input  wire logic             in_tuser,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // span_left, span_right, span_row
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast,
  // shape_done
  output logic                  out_tuser
);

  localparam int R   = RADIUS_BITS;
  localparam int C   = COORD_BITS;
  localparam int XW  = R + 2;
  localparam int MB  = R + 4;
  localparam int PW  = 2 * R + 1 + MB;
  localparam int EW  = PW + 1;
  localparam int SW  = ((C > XW) ? C : XW) + 2;
  localparam int OW  = C + 1;

  fesg_pkg::fesg_state_t state_r, state_nxt;

  logic                 active_r;
  logic [XW-1:0]        x_r;
  logic [R-1:0]         y_r;
  logic signed [EW-1:0] err_r;
  logic signed [C-1:0]  xc_r, yc_r;
  logic [R-1:0]         ra_r, rb_r;
  logic [2*R-1:0]       asq_r, bsq_r;
  logic signed [PW-1:0] prod_r;

  logic [2*R-1:0]       mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod_nxt;
  logic signed [EW-1:0] prod_ext;
  logic signed [MB-1:0] y_twice;

  logic in_fire, out_fire;
  logic in_start;

  logic signed [SW-1:0] xc_ext, yc_ext, x_ext, y_ext;
  logic signed [SW-1:0] left_w, right_w, row_w;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_start = (in_tuser == fesg_pkg::ACT_START);

  assign y_twice  = {{(MB-R-1){1'b0}}, y_r, 1'b0};
  assign prod_nxt = $signed({1'b0, mul_a}) * mul_b;
  assign prod_ext = {{(EW-PW){prod_r[PW-1]}}, prod_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fesg_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_start) state_nxt = fesg_pkg::ST_SQ_A;
          else if (active_r) state_nxt = fesg_pkg::ST_CHECK;
        end
      end
      fesg_pkg::ST_SQ_A:  state_nxt = fesg_pkg::ST_SQ_B;
      fesg_pkg::ST_SQ_B:  state_nxt = fesg_pkg::ST_INIT;
      fesg_pkg::ST_INIT:  state_nxt = fesg_pkg::ST_LOAD;
      fesg_pkg::ST_LOAD:  state_nxt = fesg_pkg::ST_CHECK;
      fesg_pkg::ST_CHECK: begin
        if (err_r[EW-1]) state_nxt = fesg_pkg::ST_ADD_X;
        else state_nxt = fesg_pkg::ST_ADD_Y;
      end
      fesg_pkg::ST_ADD_X: state_nxt = fesg_pkg::ST_CHECK;
      fesg_pkg::ST_ADD_Y: state_nxt = fesg_pkg::ST_OUT_UP;
      fesg_pkg::ST_OUT_UP: begin
        if (out_fire) state_nxt = fesg_pkg::ST_OUT_LO;
      end
      fesg_pkg::ST_OUT_LO: begin
        if (out_fire) state_nxt = fesg_pkg::ST_IDLE;
      end
      default: state_nxt = fesg_pkg::ST_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    in_tready  = (state_r == fesg_pkg::ST_IDLE);
    out_tvalid = (state_r == fesg_pkg::ST_OUT_UP) || (state_r == fesg_pkg::ST_OUT_LO);
    out_tlast  = (state_r == fesg_pkg::ST_OUT_LO);
    out_tuser  = (y_r == '0);
    mul_a = {{R{1'b0}}, ra_r};
    mul_b = {{(MB-R){1'b0}}, ra_r};
    unique case (state_r)
      fesg_pkg::ST_SQ_B: begin
        mul_a = {{R{1'b0}}, rb_r};
        mul_b = {{(MB-R){1'b0}}, rb_r};
      end
      fesg_pkg::ST_INIT: begin
        mul_a = prod_r[2*R-1:0];
        mul_b = {{(MB-R){1'b0}}, ra_r};
      end
      fesg_pkg::ST_CHECK: begin
        if (err_r[EW-1]) begin
          mul_a = bsq_r;
          mul_b = {{(MB-XW-1){1'b0}}, x_r, 1'b1};
        end else begin
          mul_a = asq_r;
          mul_b = {{(MB-1){1'b0}}, 1'b1} - y_twice;
        end
      end
      default: begin
      end
    endcase
  end

  assign xc_ext  = {{(SW-C){xc_r[C-1]}}, xc_r};
  assign yc_ext  = {{(SW-C){yc_r[C-1]}}, yc_r};
  assign x_ext   = {{(SW-XW){1'b0}}, x_r};
  assign y_ext   = {{(SW-R){1'b0}}, y_r};
  assign left_w  = xc_ext - x_ext + {{(SW-1){1'b0}}, 1'b1};
  assign right_w = xc_ext + x_ext - {{(SW-1){1'b0}}, 1'b1};
  assign row_w   = (state_r == fesg_pkg::ST_OUT_LO) ? (yc_ext + y_ext) : (yc_ext - y_ext);

  always_comb begin
    out_tdata = '0;
    out_tdata[OW-1:0]      = left_w[OW-1:0];
    out_tdata[2*OW-1:OW]   = right_w[OW-1:0];
    out_tdata[3*OW-1:2*OW] = row_w[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fesg_pkg::ST_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_start) active_r <= 1'b1;
      if ((state_r == fesg_pkg::ST_OUT_LO) && out_fire && (y_r == '0)) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    unique case (state_r)
      fesg_pkg::ST_IDLE: begin
        if (in_fire && in_start) begin
          xc_r <= in_tdata[C-1:0];
          yc_r <= in_tdata[2*C-1:C];
          ra_r <= in_tdata[2*C+R-1:2*C];
          rb_r <= in_tdata[2*C+2*R-1:2*C+R];
          y_r  <= in_tdata[2*C+2*R-1:2*C+R];
          x_r  <= '0;
        end
      end
      fesg_pkg::ST_SQ_B:  asq_r <= prod_r[2*R-1:0];
      fesg_pkg::ST_INIT:  bsq_r <= prod_r[2*R-1:0];
      fesg_pkg::ST_LOAD:  err_r <= -prod_ext;
      fesg_pkg::ST_ADD_X: begin
        err_r <= err_r + prod_ext;
        x_r   <= x_r + {{(XW-1){1'b0}}, 1'b1};
      end
      fesg_pkg::ST_ADD_Y: err_r <= err_r + prod_ext;
      fesg_pkg::ST_OUT_LO: begin
        if (out_fire && (y_r != '0)) y_r <= y_r - {{(R-1){1'b0}}, 1'b1};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb_filled_ellipse_span_generator.sv =====
// Self-checking testbench for the filled ellipse span generator.
// Predicts every span pair in SystemVerilog from the request stream, with random idling on
// both stream sides and one long output hold-off. Depends on fesg_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_filled_ellipse_span_generator;

  localparam int IN_W        = 56;
  localparam int OUT_W       = 56;
  localparam int RAND_ITEMS  = 950;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        action;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [11:0] rx;
    logic [11:0] ry;
  } ellipse_req_t;

  typedef struct {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic signed [16:0] row;
    logic               last;
    logic               done;
  } span_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             in_tuser   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic             out_tuser;

  ellipse_req_t req_q[$];
  span_t        span_q[$];

  int fail_cnt    = 0;
  int cycle_cnt   = 0;
  int req_sent    = 0;
  int spans_seen  = 0;
  int send_gap    = 0;
  int recv_gap    = 0;
  int hold_cnt    = 0;
  bit hold_done   = 1'b0;
  bit req_fire;
  bit req_showing;

  // Predictor state
  bit     shape_active = 1'b0;
  longint walk_x = 0;
  longint walk_y = 0;
  longint err_acc = 0;
  longint held_cx = 0;
  longint held_cy = 0;
  longint rx_sq = 0;
  longint ry_sq = 0;

  filled_ellipse_span_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic push_req(input logic action, input logic [15:0] cx, input logic [15:0] cy,
                          input logic [11:0] rx, input logic [11:0] ry);
    ellipse_req_t r;
    r.action = action;
    r.cx = cx;
    r.cy = cy;
    r.rx = rx;
    r.ry = ry;
    req_q.push_back(r);
  endtask

  task automatic push_continue();
    push_req(fesg_pkg::ACT_CONTINUE, 16'($urandom), 16'($urandom), 12'($urandom),
             12'($urandom));
  endtask

  task automatic predict_row_pair(input ellipse_req_t r);
    span_t  s;
    longint y;
    if (r.action == fesg_pkg::ACT_START) begin
      held_cx = longint'($signed(r.cx));
      held_cy = longint'($signed(r.cy));
      rx_sq = longint'(r.rx) * longint'(r.rx);
      ry_sq = longint'(r.ry) * longint'(r.ry);
      walk_x = 0;
      walk_y = longint'(r.ry);
      err_acc = -(ry_sq * longint'(r.rx));
      shape_active = 1'b1;
    end else if (!shape_active) begin
      return;
    end
    while (err_acc < 0) begin
      err_acc += ry_sq * (2 * walk_x + 1);
      walk_x++;
    end
    err_acc += rx_sq * (1 - 2 * walk_y);
    y = walk_y;
    s.left  = 17'(held_cx - walk_x + 1);
    s.right = 17'(held_cx + walk_x - 1);
    s.done  = (y == 0);
    s.row   = 17'(held_cy - y);
    s.last  = 1'b0;
    span_q.push_back(s);
    s.row   = 17'(held_cy + y);
    s.last  = 1'b1;
    span_q.push_back(s);
    if (y <= 0) shape_active = 1'b0;
    else walk_y = y - 1;
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      req_fire = in_tvalid && in_tready;
      if (req_fire) begin
        predict_row_pair(req_q[0]);
        void'(req_q.pop_front());
        req_sent++;
        send_gap = ((req_sent % 160) < 40) ? 0 : $urandom_range(0, 19);
      end
      req_showing = in_tvalid && !req_fire;
      if (!req_showing) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= req_q[0].action;
          in_tdata  <= {req_q[0].ry, req_q[0].rx, req_q[0].cy, req_q[0].cx};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    span_t              want;
    logic signed [16:0] got_left;
    logic signed [16:0] got_right;
    logic signed [16:0] got_row;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_left  = out_tdata[16:0];
        got_right = out_tdata[33:17];
        got_row   = out_tdata[50:34];
        spans_seen++;
        if (span_q.size() == 0) begin
          $display("%0t ERROR unexpected span: expected none, actual left %0d right %0d row %0d",
                   $time, got_left, got_right, got_row);
          fail_cnt++;
        end else begin
          want = span_q.pop_front();
          if (got_left !== want.left) begin
            $display("%0t ERROR span_left expected %0d actual %0d", $time, want.left, got_left);
            fail_cnt++;
          end
          if (got_right !== want.right) begin
            $display("%0t ERROR span_right expected %0d actual %0d",
                     $time, want.right, got_right);
            fail_cnt++;
          end
          if (got_row !== want.row) begin
            $display("%0t ERROR span_row expected %0d actual %0d", $time, want.row, got_row);
            fail_cnt++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t ERROR pair_last expected %0b actual %0b", $time, want.last, out_tlast);
            fail_cnt++;
          end
          if (out_tuser !== want.done) begin
            $display("%0t ERROR shape_done expected %0b actual %0b", $time, want.done, out_tuser);
            fail_cnt++;
          end
        end
        recv_gap = ((spans_seen % 128) < 32) ? 0 : $urandom_range(0, 19);
        if (!hold_done && spans_seen >= 150) begin
          hold_cnt = 600;
          hold_done = 1'b1;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          n_rand;
    int          kind;
    int          n_cont;
    logic [11:0] a;
    logic [11:0] b;

    // Directed: idle continue, zero radii, extremes, abandon, overrun
    push_continue();
    push_req(fesg_pkg::ACT_START, 16'd0, 16'd0, 12'd0, 12'd0);
    push_continue();
    push_req(fesg_pkg::ACT_START, 16'h7fff, 16'h8000, 12'hfff, 12'hfff);
    push_continue();
    push_continue();
    push_req(fesg_pkg::ACT_START, 16'h8000, 16'h7fff, 12'hfff, 12'd1);
    push_continue();
    push_continue();
    push_req(fesg_pkg::ACT_START, 16'd100, -16'sd100, 12'd0, 12'd3);
    repeat (3) push_continue();
    push_req(fesg_pkg::ACT_START, 16'h7fff, 16'h7fff, 12'd5, 12'd0);
    push_req(fesg_pkg::ACT_START, 16'hffff, 16'd1, 12'd3, 12'd2);
    repeat (3) push_continue();
    push_req(fesg_pkg::ACT_START, 16'h8000, 16'h8000, 12'd1, 12'hfff);
    push_continue();
    push_req(fesg_pkg::ACT_START, 16'h7fff, 16'h7fff, 12'd2, 12'd2);
    push_continue();
    push_continue();

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        a = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 12));
        b = 12'($urandom_range(0, 12));
        push_req(fesg_pkg::ACT_START, 16'($urandom), 16'($urandom), a, b);
        n_cont = b;
        if ($urandom_range(0, 4) == 0) n_cont = $urandom_range(0, b);
        else if ($urandom_range(0, 3) == 0) n_cont = b + $urandom_range(1, 2);
        repeat (n_cont) push_continue();
        n_rand += 1 + n_cont;
      end else if (kind < 92) begin
        push_req(fesg_pkg::ACT_START, 16'($urandom), 16'($urandom), 12'($urandom),
                 12'($urandom));
        n_cont = $urandom_range(0, 3);
        repeat (n_cont) push_continue();
        n_rand += 1 + n_cont;
      end else begin
        push_continue();
        n_rand++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_tvalid) @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (fail_cnt == 0 && span_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
